// ===== sv/warq_pkg.sv =====
// ----------------------------------------------------------------------------
// warq_pkg
// Shared types and codes for the windowed ARQ transport engine.
// ----------------------------------------------------------------------------
`default_nettype none
package warq_pkg;
    localparam int HEAD_BYTES = 4;
    localparam int SLOT_W     = 3;
    localparam int SEQ_W      = 16;
    localparam int LEN_W      = 9;
    localparam int TOT_W      = 12;

    typedef enum logic [1:0] {
        CMD_DATAGRAM = 2'd0,
        CMD_SEND     = 2'd1,
        CMD_READ     = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_ACK     = 3'd0,
        K_SEND    = 3'd1,
        K_STORED  = 3'd2,
        K_DELIVER = 3'd3,
        K_DONE    = 3'd4,
        K_IGNORED = 3'd5
    } kind_t;

    localparam logic [0:0] REG_WINDOW   = 1'b0;
    localparam logic [0:0] REG_INTERVAL = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] seq;
        logic [8:0]  len;
        logic [11:0] total;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

// ===== sv/warq_out_buf.sv =====
// ----------------------------------------------------------------------------
// warq_out_buf
// Two-entry output skid buffer for result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module warq_out_buf
    import warq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire res_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_data
);
    res_t       buf_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_reg] <= in_data;
        if (!aresetn) begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/warq_core.sv =====
// ----------------------------------------------------------------------------
// warq_core
// Sequencer over the send and receive slot memories (read, modify, write).
// ----------------------------------------------------------------------------
`default_nettype none
module warq_core
    import warq_pkg::*;
#(
    parameter int WINDOW_MAX  = 8,
    parameter int PAYLOAD_MAX = 504
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [8:0]  rx_length,
    input  wire logic [15:0] rx_type,
    input  wire logic [15:0] rx_index,
    input  wire logic [11:0] data_length,
    input  wire logic [3:0]  window_size,
    input  wire logic [15:0] interval,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res_data
);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int QS = 16 + WW;
    localparam int RW = QS + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DGRAM, S_SCAN, S_SEND, S_READ, S_DONE
    } state_t;

    // Memories: send entry {seq,timer,len}, recv entry {seq,len}
    logic [40:0] smem [WINDOW_MAX];
    logic [24:0] rmem [WINDOW_MAX];
    logic [40:0] srd_reg;
    logic [24:0] rrd_reg;
    logic [AW-1:0] raddr;
    logic        swe, rwe;
    logic [AW-1:0] waddr;
    logic [40:0] swd;
    logic [24:0] rwd;

    // Flags, reset-valued
    logic [WINDOW_MAX-1:0] acked_reg, got_reg, sinit_reg, rinit_reg;
    logic [WINDOW_MAX-1:0] wmask;

    state_t        st_reg;
    logic [8:0]    rxlen_reg;
    logic [15:0]   rxtype_reg, rxidx_reg;
    logic [11:0]   rem_reg;
    logic [12:0]   tot_reg;
    logic [WW-1:0] idx_reg;
    logic [AW-1:0] dslot_reg;
    logic          all_reg, phase_reg;
    logic [WW-1:0] w;
    logic [3:0]    wcl;

    always_comb begin
        wcl = (window_size == 4'd0) ? 4'd1 : window_size;
        if ({28'd0, wcl} > WINDOW_MAX) w = WW'(WINDOW_MAX);
        else w = WW'(wcl);
        for (int i = 0; i < WINDOW_MAX; i++) wmask[i] = (i < int'(w));
    end

    // Slot of rx_index: quotient by reciprocal multiply, remainder next cycle
    logic [RW-1:0]    recip_tab [WINDOW_MAX+1];
    logic [15+RW:0]   qprod;
    logic [15:0]      q_reg;
    logic [15+WW:0]   qw;
    logic [AW-1:0]    slot_calc;

    assign recip_tab[0] = '0;
    for (genvar g = 1; g <= WINDOW_MAX; g++) begin : g_recip
        localparam logic [RW-1:0] RECIP =
            RW'(((64'd1 << QS) + 64'(g) - 64'd1) / 64'(g));
        assign recip_tab[g] = RECIP;
    end

    always_comb begin
        qprod = {{RW{1'b0}}, rx_index} * {16'd0, recip_tab[w]};
        qw = {{WW{1'b0}}, q_reg} * {16'd0, w};
        slot_calc = rxidx_reg[AW-1:0] - qw[AW-1:0];
    end

    // Entry view with reset defaults applied
    logic [15:0] s_seq, s_tim, r_seq;
    logic [8:0]  s_len, r_len;
    logic [AW-1:0] cur;
    always_comb begin
        cur = (st_reg == S_DGRAM) ? dslot_reg : idx_reg[AW-1:0];
        if (sinit_reg[cur]) begin
            s_seq = srd_reg[40:25]; s_tim = srd_reg[24:9]; s_len = srd_reg[8:0];
        end else begin
            s_seq = 16'(cur); s_tim = 16'd100; s_len = 9'd0;
        end
        if (rinit_reg[cur]) begin
            r_seq = rrd_reg[24:9]; r_len = rrd_reg[8:0];
        end else begin
            r_seq = 16'(cur); r_len = 9'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (swe) smem[waddr] <= swd;
        if (rwe) rmem[waddr] <= rwd;
        srd_reg <= smem[raddr];
        rrd_reg <= rmem[raddr];
    end

    assign in_ready = (st_reg == S_IDLE);

    logic [8:0]  sz;
    logic [8:0]  pay;
    logic [15:0] tnew;
    logic        fire;
    always_comb begin
        sz = (rem_reg < 12'(PAYLOAD_MAX)) ? rem_reg[8:0] : 9'(PAYLOAD_MAX);
        pay = ((rxlen_reg - 9'(HEAD_BYTES)) > 9'(PAYLOAD_MAX)) ? 9'(PAYLOAD_MAX)
              : rxlen_reg - 9'(HEAD_BYTES);
        fire = !acked_reg[idx_reg[AW-1:0]] && (s_tim >= interval);
        tnew = fire ? 16'd1 : ((s_tim != 16'hFFFF) ? s_tim + 16'd1 : s_tim);
    end

    always_ff @(posedge aclk) begin : p_fsm
        logic res_valid_next;
        res_valid_next = res_valid && !res_ready;
        if (!aresetn) begin
            st_reg <= S_IDLE;
            acked_reg <= '0; got_reg <= '0; sinit_reg <= '0; rinit_reg <= '0;
            res_valid <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            case (st_reg)
            S_IDLE: if (in_valid) begin
                rxlen_reg <= rx_length;
                rxtype_reg <= rx_type; rxidx_reg <= rx_index;
                rem_reg <= data_length; q_reg <= qprod[QS+15:QS];
                idx_reg <= '0; tot_reg <= '0; phase_reg <= 1'b0;
                case (command)
                CMD_DATAGRAM: st_reg <= S_DGRAM;
                CMD_SEND: begin
                    all_reg <= &(acked_reg | ~wmask);
                    st_reg <= S_SEND;
                end
                CMD_READ: begin
                    all_reg <= &(got_reg | ~wmask);
                    st_reg <= S_READ;
                end
                default: begin
                    res_data <= '{K_IGNORED, 3'd0, 16'd0, 9'd0, 12'd0, 1'b1};
                    res_valid_next = 1'b1;
                    st_reg <= S_DONE;
                end
                endcase
            end
            S_DGRAM: if (!res_valid || res_ready) begin
                // memory read data is registered: phase 0 waits for it
                if (!phase_reg) begin
                    phase_reg <= 1'b1;
                    dslot_reg <= slot_calc;
                end else if (rxlen_reg < 9'(HEAD_BYTES)) begin
                    res_data <= '{K_IGNORED, 3'd0, 16'd0, 9'd0, 12'd0, 1'b1};
                    res_valid_next = 1'b1; st_reg <= S_DONE;
                end else if (rxtype_reg == 16'd0) begin
                    if (!all_reg) begin
                        res_data <= '{K_ACK, 3'(dslot_reg), rxidx_reg, 9'd0, 12'd0,
                                      r_seq != rxidx_reg};
                        res_valid_next = 1'b1;
                        all_reg <= 1'b1;
                        if (r_seq != rxidx_reg) st_reg <= S_DONE;
                    end else begin
                        got_reg[dslot_reg] <= 1'b1;
                        rinit_reg[dslot_reg] <= 1'b1;
                        res_data <= '{K_STORED, 3'(dslot_reg), rxidx_reg, pay,
                                      12'd0, 1'b1};
                        res_valid_next = 1'b1; st_reg <= S_DONE;
                    end
                end else if (rxtype_reg == 16'd1 && s_seq == rxidx_reg) begin
                    acked_reg[dslot_reg] <= 1'b1;
                    res_data <= '{K_DONE, 3'(dslot_reg), rxidx_reg, 9'd0, 12'd0, 1'b1};
                    res_valid_next = 1'b1; st_reg <= S_DONE;
                end else begin
                    res_data <= '{K_IGNORED, 3'd0, 16'd0, 9'd0, 12'd0, 1'b1};
                    res_valid_next = 1'b1; st_reg <= S_DONE;
                end
            end
            S_SEND: if (!res_valid || res_ready) begin
                if (!phase_reg) phase_reg <= 1'b1;
                else if (idx_reg == w) begin
                    if (all_reg) acked_reg <= acked_reg & ~wmask;
                    res_data <= '{K_DONE, 3'd0, 16'd0, 9'd0,
                                  all_reg ? ((tot_reg > 13'hFFF) ? 12'hFFF : tot_reg[11:0])
                                          : 12'd0, 1'b1};
                    res_valid_next = 1'b1; st_reg <= S_DONE;
                end else begin
                    sinit_reg[idx_reg[AW-1:0]] <= 1'b1;
                    rem_reg <= rem_reg - {3'd0, sz};
                    tot_reg <= tot_reg + {4'd0, sz};
                    if (fire) begin
                        res_data <= '{K_SEND, 3'(idx_reg), s_seq, sz, 12'd0, 1'b0};
                        res_valid_next = 1'b1;
                    end
                    idx_reg <= idx_reg + WW'(1);
                    phase_reg <= 1'b0;
                end
            end
            S_READ: if (!res_valid || res_ready) begin
                if (!phase_reg) phase_reg <= 1'b1;
                else if (!all_reg || idx_reg == w) begin
                    res_data <= '{K_DONE, 3'd0, 16'd0, 9'd0,
                                  (tot_reg > 13'hFFF) ? 12'hFFF : tot_reg[11:0], 1'b1};
                    res_valid_next = 1'b1; st_reg <= S_DONE;
                end else begin
                    got_reg[idx_reg[AW-1:0]] <= 1'b0;
                    rinit_reg[idx_reg[AW-1:0]] <= 1'b1;
                    tot_reg <= tot_reg + {4'd0, r_len};
                    res_data <= '{K_DELIVER, 3'(idx_reg), r_seq, r_len, 12'd0, 1'b0};
                    res_valid_next = 1'b1;
                    idx_reg <= idx_reg + WW'(1);
                    phase_reg <= 1'b0;
                end
            end
            S_DONE: begin
                all_reg <= 1'b0;
                if (!res_valid || res_ready) st_reg <= S_IDLE;
            end
            default: st_reg <= S_IDLE;
            endcase
            if (st_reg == S_IDLE && in_valid && command == CMD_DATAGRAM)
                all_reg <= 1'b0;
            res_valid <= res_valid_next;
        end
    end

    // Memory port control
    always_comb begin
        raddr = (st_reg == S_DGRAM) ? (phase_reg ? dslot_reg : slot_calc)
              : idx_reg[AW-1:0];
        waddr = cur;
        swe = 1'b0; rwe = 1'b0;
        swd = {s_seq, s_tim, s_len};
        rwd = {r_seq, r_len};
        if (phase_reg && (!res_valid || res_ready)) begin
            if (st_reg == S_SEND && idx_reg != w) begin
                swe = 1'b1;
                if (acked_reg[idx_reg[AW-1:0]] && all_reg)
                    swd = {s_seq + 16'(w), interval, sz};
                else if (all_reg)
                    swd = {s_seq + 16'(w), interval, sz};
                else if (acked_reg[idx_reg[AW-1:0]])
                    swd = {s_seq, s_tim, sz};
                else
                    swd = {s_seq, tnew, sz};
            end
            if (st_reg == S_READ && all_reg && idx_reg != w) begin
                rwe = 1'b1;
                rwd = {r_seq + 16'(w), r_len};
            end
            if (st_reg == S_DGRAM && all_reg && rxtype_reg == 16'd0
                && rxlen_reg >= 9'(HEAD_BYTES)) begin
                rwe = 1'b1;
                rwd = {r_seq, pay};
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/windowed_arq_transport_engine.sv =====
// Commands are taken one at a time, only while the sequencer is idle; a send
//   step with no slot due gives only its done beat. Send and complete read
//   steps read each slot from memory in turn; other read steps give only
//   their done beat.
// Reset: aresetn synchronous, active low; slot memories use reset-valued
// flags instead of a clearing pass, so no wait after reset.
// ----------------------------------------------------------------------------
// windowed_arq_transport_engine
// Selective-repeat ARQ header engine top level.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_arq_transport_engine
    import warq_pkg::*;
#(
    parameter int WINDOW_MAX  = 8,
    parameter int PAYLOAD_MAX = 504
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], rx_length[10:2], rx_type[26:11], rx_index[42:27],
    // data_length[54:43]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // kind[2:0], slot[5:3], seq_index[21:6], length[30:22], total_bytes[42:31]
    output logic [47:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [3:0]  win_reg;
    logic [15:0] intv_reg;
    logic        rv, rr;
    res_t        rd, od;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= 4'd2; intv_reg <= 16'd100;
        end else if (cfg_valid) begin
            case (cfg_index)
            REG_WINDOW:   win_reg <= cfg_data[3:0];
            REG_INTERVAL: intv_reg <= cfg_data;
            default: ;
            endcase
        end
    end

    warq_core #(.WINDOW_MAX(WINDOW_MAX), .PAYLOAD_MAX(PAYLOAD_MAX)) u_core (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[1:0]), .rx_length(s_tdata[10:2]),
        .rx_type(s_tdata[26:11]), .rx_index(s_tdata[42:27]),
        .data_length(s_tdata[54:43]), .window_size(win_reg),
        .interval(intv_reg), .res_valid(rv), .res_ready(rr), .res_data(rd)
    );

    warq_out_buf u_buf (
        .aclk, .aresetn, .in_valid(rv), .in_ready(rr), .in_data(rd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
    );

    assign m_tdata = {5'd0, od.total, od.len, od.seq, od.slot, od.kind};
    assign m_tlast = od.last;
endmodule
`default_nettype wire

// ===== sv/warq_checker.sv =====
// ----------------------------------------------------------------------------
// warq_checker
// Port-level checks for the ARQ engine.
// ----------------------------------------------------------------------------
`default_nettype none
module warq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("input beat dropped while stalled");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("bad result kind");
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[42:31] == 12'd0)
        else $error("total on non-final beat");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule
bind windowed_arq_transport_engine warq_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
`default_nettype wire

// ===== verif/tb_windowed_arq_transport_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_arq_transport_engine
// Checks the selective-repeat window engine beat by beat against its own
// predictor. Directed corner cases are followed by random traffic. Most
// datagrams in that traffic hit live sequence indexes, so windows complete and advance.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

import warq_pkg::*;

class arq_window_model;
    localparam int NSLOT   = 8;
    localparam int PAY_MAX = 504;

    logic [3:0]  win_reg;
    logic [15:0] interval_reg;
    logic [15:0] tx_seq [NSLOT];
    logic        tx_acked [NSLOT];
    logic [15:0] tx_timer [NSLOT];
    logic [8:0]  tx_len [NSLOT];
    logic [15:0] rx_seq [NSLOT];
    logic        rx_got [NSLOT];
    logic [8:0]  rx_len [NSLOT];
    res_t        expected_results [$];
    int          errors;

    function new();
        win_reg      = 4'd2;
        interval_reg = 16'd100;
        errors       = 0;
        for (int i = 0; i < NSLOT; i++) begin
            tx_seq[i]   = 16'(i);
            tx_acked[i] = 1'b0;
            tx_timer[i] = 16'd100;
            tx_len[i]   = '0;
            rx_seq[i]   = 16'(i);
            rx_got[i]   = 1'b0;
            rx_len[i]   = '0;
        end
    endfunction

    function int slots();
        int w;
        w = int'(win_reg);
        if (w == 0) w = 1;
        if (w > NSLOT) w = NSLOT;
        return w;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
        if (idx == REG_WINDOW) win_reg = val[3:0];
        else interval_reg = val;
    endfunction

    function void push(kind_t k, int s, logic [15:0] seq, int len, int total);
        res_t r;
        r.kind  = k;
        r.slot  = 3'(s);
        r.seq   = seq;
        r.len   = 9'(len);
        r.total = 12'(total);
        r.last  = 1'b0;
        expected_results.push_back(r);
    endfunction

    function void note_beat(logic [55:0] d);
        logic [1:0]  cmd;
        logic [8:0]  rlen;
        logic [15:0] rtype;
        logic [15:0] ridx;
        int          w, s, pay, rem, sz, total;
        bit          all;
        cmd   = d[1:0];
        rlen  = d[10:2];
        rtype = d[26:11];
        ridx  = d[42:27];
        rem   = int'(d[54:43]);
        w     = slots();
        total = 0;
        all   = 1'b1;
        if (cmd == CMD_DATAGRAM) begin
            s = int'(ridx) % w;
            if (rlen < HEAD_BYTES) begin
                push(K_IGNORED, 0, 0, 0, 0);
            end else if (rtype == 0) begin
                pay = int'(rlen) - HEAD_BYTES;
                if (pay > PAY_MAX) pay = PAY_MAX;
                push(K_ACK, s, ridx, 0, 0);
                if (rx_seq[s] == ridx) begin
                    rx_got[s] = 1'b1;
                    rx_len[s] = 9'(pay);
                    push(K_STORED, s, ridx, pay, 0);
                end
            end else if (rtype == 1 && tx_seq[s] == ridx) begin
                tx_acked[s] = 1'b1;
                push(K_DONE, s, ridx, 0, 0);
            end else begin
                push(K_IGNORED, 0, 0, 0, 0);
            end
        end else if (cmd == CMD_SEND) begin
            for (int i = 0; i < w; i++) if (!tx_acked[i]) all = 1'b0;
            for (int i = 0; i < w; i++) begin
                sz = (rem < PAY_MAX) ? rem : PAY_MAX;
                tx_len[i] = 9'(sz);
                rem -= sz;
                if (!tx_acked[i]) begin
                    if (tx_timer[i] >= interval_reg) begin
                        push(K_SEND, i, tx_seq[i], sz, 0);
                        tx_timer[i] = '0;
                    end
                    if (tx_timer[i] != 16'hFFFF) tx_timer[i] = tx_timer[i] + 16'd1;
                end
            end
            if (all) begin
                for (int i = 0; i < w; i++) begin
                    total += int'(tx_len[i]);
                    tx_acked[i] = 1'b0;
                    tx_seq[i]   = tx_seq[i] + 16'(w);
                    tx_timer[i] = interval_reg;
                end
                if (total > 4095) total = 4095;
            end
            push(K_DONE, 0, 0, 0, total);
        end else if (cmd == CMD_READ) begin
            for (int i = 0; i < w; i++) if (!rx_got[i]) all = 1'b0;
            if (all) begin
                for (int i = 0; i < w; i++) begin
                    push(K_DELIVER, i, rx_seq[i], int'(rx_len[i]), 0);
                    total += int'(rx_len[i]);
                    rx_got[i] = 1'b0;
                    rx_seq[i] = rx_seq[i] + 16'(w);
                end
                if (total > 4095) total = 4095;
            end
            push(K_DONE, 0, 0, 0, total);
        end else begin
            push(K_IGNORED, 0, 0, 0, 0);
        end
        expected_results[$].last = 1'b1;
    endfunction

    function void check_beat(logic [47:0] d, logic lst);
        res_t e;
        if (expected_results.size() == 0) begin
            $error("unexpected result beat %h", d);
            errors++;
            return;
        end
        e = expected_results.pop_front();
        if (d[2:0] != e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, d[2:0]); errors++;
        end
        if (d[5:3] != e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, d[5:3]); errors++;
        end
        if (d[21:6] != e.seq) begin
            $error("seq_index: expected %0d, got %0d", e.seq, d[21:6]); errors++;
        end
        if (d[30:22] != e.len) begin
            $error("length: expected %0d, got %0d", e.len, d[30:22]); errors++;
        end
        if (d[42:31] != e.total) begin
            $error("total_bytes: expected %0d, got %0d", e.total, d[42:31]); errors++;
        end
        if (lst != e.last) begin
            $error("last: expected %0d, got %0d", e.last, lst); errors++;
        end
    endfunction
endclass

module tb_windowed_arq_transport_engine;
    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam int         LIMIT   = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    arq_window_model model = new();
    int cycles  = 0;
    int hold_off = 0;

    windowed_arq_transport_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_windowed_arq_transport_engine: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.check_beat(m_tdata, m_tlast);
    end

    // receiver: ready pattern changes every stretch; hold_off forces a long stall
    initial begin
        int mode, left;
        mode = 0;
        left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 80);
            end
            left--;
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (mode == 0) begin
                m_tready <= 1'b1;
            end else if (mode == 1) begin
                m_tready <= 1'($urandom_range(0, 1));
            end else begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    function automatic logic [55:0] pack(logic [1:0] cmd, logic [8:0] len, logic [15:0] ty,
                                         logic [15:0] idx, logic [11:0] dlen);
        return {1'b0, dlen, idx, ty, len, cmd};
    endfunction

    task automatic offer(logic [55:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model.note_beat(d);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        pause(1);
        while (model.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [55:0] random_item();
        int          pick, w, s;
        logic [8:0]  len;
        logic [15:0] ty, idx;
        logic [11:0] dlen;
        pick = $urandom_range(0, 99);
        w    = model.slots();
        s    = $urandom_range(0, w - 1);
        len  = 9'($urandom_range(4, 511));
        ty   = 16'($urandom);
        idx  = 16'($urandom);
        dlen = 12'($urandom);
        if ($urandom_range(0, 3) == 0) dlen = 12'($urandom_range(0, 600));
        if (pick < 30) begin
            if ($urandom_range(0, 4) != 0) idx = model.rx_seq[s];
            return pack(CMD_DATAGRAM, len, 16'd0, idx, dlen);
        end else if (pick < 50) begin
            if ($urandom_range(0, 4) != 0) idx = model.tx_seq[s];
            return pack(CMD_DATAGRAM, len, 16'd1, idx, dlen);
        end else if (pick < 65) begin
            return pack(CMD_SEND, len, ty, idx, dlen);
        end else if (pick < 80) begin
            return pack(CMD_READ, len, ty, idx, dlen);
        end else if (pick < 88) begin
            return pack(CMD_DATAGRAM, 9'($urandom), ty, idx, dlen);
        end else if (pick < 95) begin
            return pack(CMD_BAD, len, ty, idx, dlen);
        end
        return pack(CMD_DATAGRAM, 9'($urandom_range(0, 3)), ty & 16'h1, idx, dlen);
    endfunction

    initial begin
        int          win_set [8] = '{1, 8, 2, 5, 0, 15, 3, 8};
        int          ivl_set [8] = '{1, 65535, 100, 3, 2, 1, 7, 65535};
        int          burst;
        logic [15:0] hi;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WINDOW;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(pack(CMD_DATAGRAM, 9'd0, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd3, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd511, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd4, 16'd0, 16'd1, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd100, 16'd0, 16'd5, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd100, 16'hFFFF, 16'hFFFF, 12'hFFF));
        offer(pack(CMD_DATAGRAM, 9'd4, 16'd1, 16'hFFFF, 12'd0));
        offer(pack(CMD_SEND, 9'd0, 16'd0, 16'd0, 12'd700));
        offer(pack(CMD_DATAGRAM, 9'd4, 16'd1, 16'd0, 12'd0));
        offer(pack(CMD_DATAGRAM, 9'd4, 16'd1, 16'd1, 12'd0));
        offer(pack(CMD_SEND, 9'd0, 16'd0, 16'd0, 12'hFFF));
        offer(pack(CMD_SEND, 9'd0, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_READ, 9'd0, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_READ, 9'd0, 16'd0, 16'd0, 12'd0));
        offer(pack(CMD_BAD, 9'h1FF, 16'hFFFF, 16'hFFFF, 12'hFFF));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            hi = 16'($urandom);
            write_cfg(REG_WINDOW, {hi[15:4], 4'(win_set[p])});
            write_cfg(REG_INTERVAL, 16'(ivl_set[p]));
            if (p == 3) hold_off = 400;
            for (int n = 0; n < 40; n += burst) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++) offer(random_item());
                if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (model.errors == 0 && model.expected_results.size() == 0) begin
            $display("tb_windowed_arq_transport_engine: clean");
        end else begin
            $display("tb_windowed_arq_transport_engine: errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
sv/warq_pkg.sv
sv/warq_out_buf.sv
sv/warq_core.sv
sv/windowed_arq_transport_engine.sv
sv/warq_checker.sv
verif/tb_windowed_arq_transport_engine.sv
